@@ sv/nrth_pkg.sv @@
// ----------------------------------------------------------------------------
// nrth_pkg
// Shared widths, codes and the multiply-accumulate program for the nearest
// ray-triangle hit block.
// ----------------------------------------------------------------------------
package nrth_pkg;

    localparam int COORD_W   = 32;
    localparam int EDGE_W    = 33;
    localparam int MA_W      = 52;
    localparam int MB_W      = 34;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ACC_W     = 88;
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 31;
    localparam int EPS_W     = 16;
    localparam int FACE_W    = 10;
    localparam int COUNT_W   = 11;

    localparam int IN_DATA_W   = 9 * COORD_W;
    localparam int OUT_DATA_W  = 152;
    localparam int HIT_FIELDS_W = FACE_W + DIST_W + 3 * COORD_W;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_RAY   = 2'd2;

    localparam logic REG_DET_EPS = 1'b0;

    typedef enum logic [4:0] {
        SRC_DIR0 = 5'd0,  SRC_DIR1 = 5'd1,  SRC_DIR2 = 5'd2,
        SRC_S0   = 5'd3,  SRC_S1   = 5'd4,  SRC_S2   = 5'd5,
        SRC_E1_0 = 5'd6,  SRC_E1_1 = 5'd7,  SRC_E1_2 = 5'd8,
        SRC_E2_0 = 5'd9,  SRC_E2_1 = 5'd10, SRC_E2_2 = 5'd11,
        SRC_P0   = 5'd12, SRC_P1   = 5'd13, SRC_P2   = 5'd14,
        SRC_Q0   = 5'd15, SRC_Q1   = 5'd16, SRC_Q2   = 5'd17,
        SRC_BEST = 5'd18
    } src_t;

    localparam int SRC_NUM = 19;

    typedef enum logic [3:0] {
        DST_NONE = 4'd0,
        DST_P0   = 4'd1, DST_P1 = 4'd2, DST_P2 = 4'd3,
        DST_Q0   = 4'd4, DST_Q1 = 4'd5, DST_Q2 = 4'd6,
        DST_DET  = 4'd7, DST_U  = 4'd8, DST_V  = 4'd9, DST_N = 4'd10,
        DST_HX   = 4'd11, DST_HY = 4'd12, DST_HZ = 4'd13
    } dst_t;

    typedef struct packed {
        src_t a;
        src_t b;
        logic neg;
        logic first;
        dst_t dst;
    } uop_t;

    localparam logic [4:0] UOP_TRI_LAST  = 5'd23;
    localparam logic [4:0] UOP_HIT_FIRST = 5'd24;
    localparam logic [4:0] UOP_LAST      = 5'd26;

    function automatic uop_t mk(input src_t a, input src_t b, input logic neg,
                                input logic first, input dst_t dst);
        uop_t u;
        u.a = a;
        u.b = b;
        u.neg = neg;
        u.first = first;
        u.dst = dst;
        return u;
    endfunction

    // p = dir x e2, q = s x e1, det = e1.p, u = s.p, v = dir.q, n = e2.q,
    // then dir * distance per axis for the hit point
    function automatic uop_t uop_rom(input logic [4:0] idx);
        uop_t u;
        case (idx)
            5'd0:  u = mk(SRC_DIR1, SRC_E2_2, 1'b0, 1'b1, DST_NONE);
            5'd1:  u = mk(SRC_DIR2, SRC_E2_1, 1'b1, 1'b0, DST_P0);
            5'd2:  u = mk(SRC_DIR2, SRC_E2_0, 1'b0, 1'b1, DST_NONE);
            5'd3:  u = mk(SRC_DIR0, SRC_E2_2, 1'b1, 1'b0, DST_P1);
            5'd4:  u = mk(SRC_DIR0, SRC_E2_1, 1'b0, 1'b1, DST_NONE);
            5'd5:  u = mk(SRC_DIR1, SRC_E2_0, 1'b1, 1'b0, DST_P2);
            5'd6:  u = mk(SRC_S1,   SRC_E1_2, 1'b0, 1'b1, DST_NONE);
            5'd7:  u = mk(SRC_S2,   SRC_E1_1, 1'b1, 1'b0, DST_Q0);
            5'd8:  u = mk(SRC_S2,   SRC_E1_0, 1'b0, 1'b1, DST_NONE);
            5'd9:  u = mk(SRC_S0,   SRC_E1_2, 1'b1, 1'b0, DST_Q1);
            5'd10: u = mk(SRC_S0,   SRC_E1_1, 1'b0, 1'b1, DST_NONE);
            5'd11: u = mk(SRC_S1,   SRC_E1_0, 1'b1, 1'b0, DST_Q2);
            5'd12: u = mk(SRC_P0,   SRC_E1_0, 1'b0, 1'b1, DST_NONE);
            5'd13: u = mk(SRC_P1,   SRC_E1_1, 1'b0, 1'b0, DST_NONE);
            5'd14: u = mk(SRC_P2,   SRC_E1_2, 1'b0, 1'b0, DST_DET);
            5'd15: u = mk(SRC_P0,   SRC_S0,   1'b0, 1'b1, DST_NONE);
            5'd16: u = mk(SRC_P1,   SRC_S1,   1'b0, 1'b0, DST_NONE);
            5'd17: u = mk(SRC_P2,   SRC_S2,   1'b0, 1'b0, DST_U);
            5'd18: u = mk(SRC_Q0,   SRC_DIR0, 1'b0, 1'b1, DST_NONE);
            5'd19: u = mk(SRC_Q1,   SRC_DIR1, 1'b0, 1'b0, DST_NONE);
            5'd20: u = mk(SRC_Q2,   SRC_DIR2, 1'b0, 1'b0, DST_V);
            5'd21: u = mk(SRC_Q0,   SRC_E2_0, 1'b0, 1'b1, DST_NONE);
            5'd22: u = mk(SRC_Q1,   SRC_E2_1, 1'b0, 1'b0, DST_NONE);
            5'd23: u = mk(SRC_Q2,   SRC_E2_2, 1'b0, 1'b0, DST_N);
            5'd24: u = mk(SRC_DIR0, SRC_BEST, 1'b0, 1'b1, DST_HX);
            5'd25: u = mk(SRC_DIR1, SRC_BEST, 1'b0, 1'b1, DST_HY);
            5'd26: u = mk(SRC_DIR2, SRC_BEST, 1'b0, 1'b1, DST_HZ);
            default: u = mk(SRC_DIR0, SRC_DIR0, 1'b0, 1'b1, DST_NONE);
        endcase
        return u;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = ACC_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}));
        if (x > hi) begin
            return hi[COORD_W-1:0];
        end else if (x < lo) begin
            return lo[COORD_W-1:0];
        end
        return x[COORD_W-1:0];
    endfunction

endpackage

@@ sv/nearest_ray_triangle_hit.sv @@
// ----------------------------------------------------------------------------
// nearest_ray_triangle_hit
// Triangle store with a nearest-hit ray test on one shared serial multiplier.
// ----------------------------------------------------------------------------
// Clear, unused and add requests do not use the multiplier.
// Ray: the serial multiplier runs 24 times per stored triangle, the divider
//   runs when a triangle passes the hit test, and the multiplier runs 3 more
//   times for the hit point on a hit; the multiplier passes set the ray time.
// One request at a time; a result may wait in the output register.
// Reset (synchronous): store empty, det_epsilon = 1; vertex memory not cleared.
module nearest_ray_triangle_hit #(
    parameter int MAX_TRIANGLES = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [nrth_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // face_index, hit_distance, hit_x, hit_y, hit_z, stored_count, zero pad
    output logic [nrth_pkg::OUT_DATA_W-1:0]    m_tdata,
    // hit, status
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import nrth_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
    localparam int DEPTH  = MAX_TRIANGLES * 9;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_WRITE = 10'b0000000010,
        ST_LOAD  = 10'b0000000100,
        ST_MGO   = 10'b0000001000,
        ST_MWAIT = 10'b0000010000,
        ST_NEG   = 10'b0000100000,
        ST_CHECK = 10'b0001000000,
        ST_DIV   = 10'b0010000000,
        ST_NEXT  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t                    state_reg;
    logic [EPS_W-1:0]          eps_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [ADDR_W-1:0]         wr_base_reg;
    logic [ADDR_W-1:0]         rd_ptr_reg;
    logic [3:0]                wr_cnt_reg;
    logic [3:0]                ld_cnt_reg;
    logic [CNT_W-1:0]          face_reg;
    logic [4:0]                uop_reg;
    logic signed [COORD_W-1:0] in_reg  [9];
    logic signed [COORD_W-1:0] vtx_reg [9];
    logic signed [MA_W-1:0]    p_reg   [3];
    logic signed [MA_W-1:0]    q_reg   [3];
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   det_reg;
    logic signed [ACC_W-1:0]   u_reg;
    logic signed [ACC_W-1:0]   v_reg;
    logic signed [ACC_W-1:0]   n_reg;
    logic                      found_reg;
    logic                      status_reg;
    logic [DIST_W-1:0]         best_reg;
    logic [CNT_W-1:0]          best_face_reg;
    logic signed [COORD_W-1:0] h_reg [3];
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    logic signed [EDGE_W-1:0]  e1 [3];
    logic signed [EDGE_W-1:0]  e2 [3];
    logic signed [EDGE_W-1:0]  sv [3];
    logic signed [MA_W-1:0]    src_val [SRC_NUM];
    uop_t                      uop;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_shift;
    logic signed [ACC_W-1:0]   eps_ext;
    logic signed [ACC_W-1:0]   uv_sum;
    logic                      pass;
    logic                      div_start;
    logic                      div_done;
    logic [DIST_W-1:0]         div_quo;
    logic [3:0]                ld_idx;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [31:0]               mem_rdata;
    logic                      cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_DET_EPS) ? 32'(eps_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(1);
        end else if (cfg_wr && paddr[2] == REG_DET_EPS) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    // operands
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = EDGE_W'(vtx_reg[3 + k]) - EDGE_W'(vtx_reg[k]);
            e2[k] = EDGE_W'(vtx_reg[6 + k]) - EDGE_W'(vtx_reg[k]);
            sv[k] = EDGE_W'(in_reg[k]) - EDGE_W'(vtx_reg[k]);
        end
        for (int k = 0; k < 3; k++) begin
            src_val[int'(SRC_DIR0) + k] = MA_W'(in_reg[3 + k]);
            src_val[int'(SRC_S0) + k]   = MA_W'(sv[k]);
            src_val[int'(SRC_E1_0) + k] = MA_W'(e1[k]);
            src_val[int'(SRC_E2_0) + k] = MA_W'(e2[k]);
            src_val[int'(SRC_P0) + k]   = p_reg[k];
            src_val[int'(SRC_Q0) + k]   = q_reg[k];
        end
        src_val[SRC_BEST] = MA_W'(signed'({1'b0, best_reg}));
    end

    assign uop       = uop_rom(uop_reg);
    assign mul_start = (state_reg == ST_MGO);
    assign prod_ext  = ACC_W'(mul_prod);
    assign acc_next  = (uop.first ? '0 : acc_reg) + (uop.neg ? -prod_ext : prod_ext);
    assign acc_shift = acc_next >>> FRAC_BITS;

    assign eps_ext = ACC_W'(signed'({1'b0, eps_reg, {FRAC_BITS{1'b0}}}));
    assign uv_sum  = u_reg + v_reg;
    assign pass    = (det_reg > eps_ext) && !u_reg[ACC_W-1] && (u_reg <= det_reg)
                   && !v_reg[ACC_W-1] && (uv_sum <= det_reg) && !n_reg[ACC_W-1];
    assign div_start = (state_reg == ST_CHECK) && pass;

    assign ld_idx    = 4'(ld_cnt_reg - 4'd1);
    assign mem_we    = (state_reg == ST_WRITE);
    assign mem_waddr = ADDR_W'(wr_base_reg + ADDR_W'(wr_cnt_reg));

    nrth_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_reg[wr_cnt_reg]),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    nrth_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (src_val[uop.a]),
        .b       (MB_W'(src_val[uop.b])),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    nrth_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (n_reg),
        .den     (det_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            wr_base_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int k = 0; k < 9; k++) begin
                            in_reg[k] <= s_tdata[COORD_W*k +: COORD_W];
                        end
                        found_reg  <= 1'b0;
                        status_reg <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            h_reg[k] <= '0;
                        end
                        wr_cnt_reg <= '0;
                        ld_cnt_reg <= '0;
                        rd_ptr_reg <= '0;
                        face_reg   <= '0;
                        case (s_tuser)
                            KIND_CLEAR: begin
                                count_reg   <= '0;
                                wr_base_reg <= '0;
                                state_reg   <= ST_DONE;
                            end
                            KIND_ADD: begin
                                if (count_reg < CNT_W'(MAX_TRIANGLES)) begin
                                    state_reg <= ST_WRITE;
                                end else begin
                                    status_reg <= 1'b1;
                                    state_reg  <= ST_DONE;
                                end
                            end
                            KIND_RAY: begin
                                state_reg <= (count_reg != '0) ? ST_LOAD : ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_WRITE: begin
                    wr_cnt_reg <= wr_cnt_reg + 4'd1;
                    if (wr_cnt_reg == 4'd8) begin
                        count_reg   <= count_reg + 1'b1;
                        wr_base_reg <= ADDR_W'(wr_base_reg + ADDR_W'(9));
                        state_reg   <= ST_DONE;
                    end
                end
                ST_LOAD: begin
                    if (ld_cnt_reg != 4'd9) begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end
                    if (ld_cnt_reg != 4'd0) begin
                        vtx_reg[ld_idx] <= mem_rdata;
                    end
                    ld_cnt_reg <= ld_cnt_reg + 4'd1;
                    if (ld_cnt_reg == 4'd9) begin
                        uop_reg   <= '0;
                        state_reg <= ST_MGO;
                    end
                end
                ST_MGO: begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mul_done) begin
                        acc_reg <= acc_next;
                        uop_reg <= uop_reg + 5'd1;
                        case (uop.dst)
                            DST_P0:  p_reg[0] <= MA_W'(acc_shift);
                            DST_P1:  p_reg[1] <= MA_W'(acc_shift);
                            DST_P2:  p_reg[2] <= MA_W'(acc_shift);
                            DST_Q0:  q_reg[0] <= MA_W'(acc_shift);
                            DST_Q1:  q_reg[1] <= MA_W'(acc_shift);
                            DST_Q2:  q_reg[2] <= MA_W'(acc_shift);
                            DST_DET: det_reg <= acc_next;
                            DST_U:   u_reg <= acc_next;
                            DST_V:   v_reg <= acc_next;
                            DST_N:   n_reg <= acc_next;
                            DST_HX:  h_reg[0] <= sat32(ACC_W'(in_reg[0]) + acc_shift);
                            DST_HY:  h_reg[1] <= sat32(ACC_W'(in_reg[1]) + acc_shift);
                            DST_HZ:  h_reg[2] <= sat32(ACC_W'(in_reg[2]) + acc_shift);
                            default: ;
                        endcase
                        if (uop_reg == UOP_TRI_LAST) begin
                            state_reg <= ST_NEG;
                        end else if (uop_reg == UOP_LAST) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_MGO;
                        end
                    end
                end
                ST_NEG: begin
                    if (det_reg[ACC_W-1]) begin
                        det_reg <= -det_reg;
                        u_reg   <= -u_reg;
                        v_reg   <= -v_reg;
                        n_reg   <= -n_reg;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    state_reg <= pass ? ST_DIV : ST_NEXT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (div_quo != '0 && (!found_reg || div_quo < best_reg)) begin
                            found_reg     <= 1'b1;
                            best_reg      <= div_quo;
                            best_face_reg <= face_reg;
                        end
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    face_reg   <= face_reg + 1'b1;
                    ld_cnt_reg <= '0;
                    if (CNT_W'(face_reg + 1'b1) == count_reg) begin
                        if (found_reg) begin
                            uop_reg   <= UOP_HIT_FIRST;
                            state_reg <= ST_MGO;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {status_reg, found_reg};
                        m_tdata_reg  <= {4'd0, COUNT_W'(count_reg),
                                         h_reg[2], h_reg[1], h_reg[0],
                                         found_reg ? best_reg : DIST_W'(0),
                                         found_reg ? FACE_W'(best_face_reg) : FACE_W'(0)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sv/nrth_store.sv @@
// ----------------------------------------------------------------------------
// nrth_store
// Triangle vertex memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nrth_store #(
    parameter int DEPTH  = 9216,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/nrth_mul.sv @@
// ----------------------------------------------------------------------------
// nrth_mul
// Serial signed multiplier, one bit of the narrow operand per cycle.
// ----------------------------------------------------------------------------
module nrth_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [nrth_pkg::MA_W-1:0]    a,
    input  logic signed [nrth_pkg::MB_W-1:0]    b,
    output logic                                done,
    output logic signed [nrth_pkg::PROD_W-1:0]  prod
);
    import nrth_pkg::*;

    localparam int CNT_W = $clog2(MB_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] ma_reg;
    logic [MB_W-1:0]   mb_reg;
    logic [PROD_W-1:0] pacc_reg;
    logic [PROD_W-1:0] pacc_next;
    logic              neg_reg;
    logic [MA_W-1:0]   a_mag;
    logic [MB_W-1:0]   b_mag;

    assign a_mag = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
    assign b_mag = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
    assign pacc_next = mb_reg[0] ? pacc_reg + ma_reg : pacc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                ma_reg   <= PROD_W'(a_mag);
                mb_reg   <= b_mag;
                pacc_reg <= '0;
                neg_reg  <= a[MA_W-1] ^ b[MB_W-1];
            end else if (busy_reg) begin
                pacc_reg <= pacc_next;
                ma_reg   <= ma_reg << 1;
                mb_reg   <= mb_reg >> 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MB_W - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    prod     <= neg_reg ? -signed'(pacc_next) : signed'(pacc_next);
                end
            end
        end
    end

endmodule

@@ sv/nrth_div.sv @@
// ----------------------------------------------------------------------------
// nrth_div
// Restoring divider for the hit distance, floor(num * 2^FRAC / den),
// saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrth_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [nrth_pkg::ACC_W-1:0]       num,
    input  logic [nrth_pkg::ACC_W-1:0]       den,
    output logic                             done,
    output logic [nrth_pkg::DIST_W-1:0]      quo
);
    import nrth_pkg::*;

    localparam int NF_W  = ACC_W + FRAC_BITS;
    localparam int REM_W = ACC_W + 1;
    localparam int CNT_W = $clog2(DIST_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] bits_reg;
    logic [DIST_W-1:0] q_reg;
    logic [ACC_W-1:0]  den_reg;
    logic [NF_W-1:0]   nfull;
    logic [REM_W-1:0]  hi;
    logic [REM_W-1:0]  trial;
    logic              qbit;
    logic [DIST_W-1:0] q_next;

    assign nfull  = {num, {FRAC_BITS{1'b0}}};
    assign hi     = REM_W'(nfull[NF_W-1:DIST_W]);
    assign trial  = {rem_reg[ACC_W-1:0], bits_reg[DIST_W-1]};
    assign qbit   = trial >= REM_W'(den_reg);
    assign q_next = {q_reg[DIST_W-2:0], qbit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                den_reg <= den;
                if (hi >= REM_W'(den)) begin
                    done <= 1'b1;
                    quo  <= '1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= hi;
                    bits_reg <= nfull[DIST_W-1:0];
                    q_reg    <= '0;
                end
            end else if (busy_reg) begin
                rem_reg  <= qbit ? trial - REM_W'(den_reg) : trial;
                bits_reg <= bits_reg << 1;
                q_reg    <= q_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIST_W - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    quo      <= q_next;
                end
            end
        end
    end

endmodule

@@ sv/nrth_checker.sv @@
// ----------------------------------------------------------------------------
// nrth_checker
// Port-level checks for the nearest ray-triangle hit block.
// ----------------------------------------------------------------------------
module nrth_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [nrth_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                       m_tuser
);
    import nrth_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[HIT_FIELDS_W-1:0] == '0)
        else $error("hit fields set without hit");

    a_drop_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("dropped add reports a hit");

endmodule

bind nearest_ray_triangle_hit nrth_checker u_nrth_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
